FILE: design/ucfd_pkg.sv
// Shared constants, types and helper functions of the comb filter with fractional delay.
package ucfd_pkg;

  localparam int unsigned DELAY_DEPTH = 131072;
  localparam int unsigned CHANNELS    = 2;
  localparam int unsigned AW          = $clog2(DELAY_DEPTH);
  localparam int unsigned SW          = 16;
  localparam int unsigned WORD_W      = 2 * SW;
  localparam int unsigned PW          = (AW + 10 > 26) ? AW + 10 : 26;
  localparam int unsigned CFG_IW      = 3;
  localparam int unsigned CFG_DW      = 26;

  localparam logic [15:0]       ONE_Q15     = 16'd32768;
  localparam logic [25:0]       DELAY_RESET = 26'd12288000;
  localparam logic [PW-1:0]     SPAN        = PW'(DELAY_DEPTH) << 8;
  localparam logic [PW-1:0]     MIN_DELAY   = PW'(256);
  localparam logic [AW-1:0]     LAST_ADDR   = AW'(DELAY_DEPTH - 1);

  typedef enum logic [CFG_IW-1:0] {
    CFG_FEEDBACK,
    CFG_FEEDFORWARD,
    CFG_BLEND,
    CFG_WET,
    CFG_DELAY
  } cfg_reg_e;

  typedef enum logic [3:0] {
    LS_HOLD,
    LS_LOAD,
    LS_D,
    LS_XH,
    LS_FF,
    LS_BL_LO,
    LS_BL_HI,
    LS_DRY,
    LS_WET_LO,
    LS_WET_HI
  } lane_step_e;

  typedef struct packed {
    lane_step_e  step;
    logic [7:0]  frac;
    logic [15:0] fb;
    logic [15:0] ff;
    logic [15:0] bl;
    logic [15:0] wet;
  } lane_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'sh7fff;
    end else if (v < -24'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic logic [15:0] clamp_gain(input logic [15:0] g);
    return (g > ONE_Q15) ? ONE_Q15 : g;
  endfunction

endpackage

FILE: design/ucfd_store.sv
// Delay store: synchronous memory with one write port and one registered read port.
module ucfd_store (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ucfd_pkg::AW-1:0]       waddr_i,
  input  logic [ucfd_pkg::WORD_W-1:0]   wdata_i,
  input  logic [ucfd_pkg::AW-1:0]       raddr_i,
  output logic [ucfd_pkg::WORD_W-1:0]   rdata_o
);
  import ucfd_pkg::*;

  logic [WORD_W-1:0] mem [0:DELAY_DEPTH-1];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ucfd_lane.sv
// One channel lane: interpolation, feedback and mix on a shared multiply-accumulate unit.
module ucfd_lane (
  input  logic                        clk_i,
  input  ucfd_pkg::lane_ctl_t         ctl_i,
  input  logic signed [15:0]          x_i,
  input  logic signed [15:0]          a_i,
  input  logic signed [15:0]          b_i,
  output logic signed [15:0]          out_o,
  output logic signed [15:0]          store_o
);
  import ucfd_pkg::*;

  typedef enum logic [1:0] {SH_0, SH_15, SH_23, SH_24} shift_e;

  logic signed [15:0] a_q;
  logic signed [16:0] diff_q;
  logic signed [24:0] d_q;
  logic signed [40:0] xh_q;
  logic signed [41:0] mr_q;
  logic signed [59:0] acc_q;
  logic signed [59:0] acc_d;

  logic signed [24:0] opa;
  logic signed [17:0] opb;
  logic signed [42:0] prod;
  logic signed [59:0] prod_ext;
  logic signed [59:0] addend;
  logic signed [59:0] base;
  logic               clr;
  shift_e             shift;
  logic [16:0]        dry;

  logic signed [59:0] mix_rnd;
  logic signed [59:0] o_rnd;
  logic signed [40:0] xh_rnd;

  assign dry = 17'(ONE_Q15) - {1'b0, ctl_i.wet};

  always_comb begin
    opa   = '0;
    opb   = '0;
    base  = '0;
    clr   = 1'b0;
    shift = SH_0;
    case (ctl_i.step)
      LS_D: begin
        opa  = 25'(diff_q);
        opb  = {10'b0, ctl_i.frac};
        base = 60'(a_q) <<< 8;
        clr  = 1'b1;
      end
      LS_XH: begin
        opa  = $signed(acc_q[24:0]);
        opb  = {2'b0, ctl_i.fb};
        base = 60'(x_i) <<< 23;
        clr  = 1'b1;
      end
      LS_FF: begin
        opa   = d_q;
        opb   = {2'b0, ctl_i.ff};
        clr   = 1'b1;
        shift = SH_15;
      end
      LS_BL_LO: begin
        opa = {1'b0, xh_q[23:0]};
        opb = {2'b0, ctl_i.bl};
      end
      LS_BL_HI: begin
        opa   = {9'b0, ctl_i.bl};
        opb   = 18'($signed(xh_q[40:24]));
        shift = SH_24;
      end
      LS_DRY: begin
        opa   = 25'(x_i);
        opb   = {1'b0, dry};
        clr   = 1'b1;
        shift = SH_23;
      end
      LS_WET_LO: begin
        opa = {1'b0, mr_q[23:0]};
        opb = {2'b0, ctl_i.wet};
      end
      LS_WET_HI: begin
        opa   = {9'b0, ctl_i.wet};
        opb   = $signed(mr_q[41:24]);
        shift = SH_24;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign prod     = opa * opb;
  assign prod_ext = 60'(prod);

  always_comb begin
    case (shift)
      SH_15:   addend = prod_ext <<< 15;
      SH_23:   addend = prod_ext <<< 23;
      SH_24:   addend = prod_ext <<< 24;
      default: addend = prod_ext;
    endcase
  end

  assign acc_d   = (clr ? base : acc_q) + addend;
  assign mix_rnd = acc_q + 60'sd16384;
  assign o_rnd   = acc_q + 60'sd137438953472;
  assign xh_rnd  = xh_q + 41'sd4194304;

  always_ff @(posedge clk_i) begin
    case (ctl_i.step)
      LS_LOAD: begin
        a_q    <= a_i;
        diff_q <= 17'(b_i) - 17'(a_i);
      end
      LS_XH:   d_q  <= $signed(acc_q[24:0]);
      LS_FF:   xh_q <= $signed(acc_q[40:0]);
      LS_DRY:  mr_q <= $signed(mix_rnd[56:15]);
      default: ;
    endcase
    if (ctl_i.step != LS_HOLD && ctl_i.step != LS_LOAD) begin
      acc_q <= acc_d;
    end
  end

  assign out_o   = sat16(24'($signed(o_rnd[59:38])));
  assign store_o = sat16(24'($signed(xh_rnd[40:23])));

endmodule

FILE: design/universal_comb_fractional_delay.sv
// Top level of the comb filter with fractional delay: control, registers and lanes.
//
// Input frames arrive on the s_axis channel (left sample in the low half of tdata),
// filtered frames leave on m_axis in the same layout. The cfg channel writes the
// gain and delay registers by index and is always ready; write it only while idle.
// A frame is processed by a sequencer: it computes the read position, reads the
// two neighboring delay entries one after the other through the single read port,
// then each channel lane runs eight multiply-accumulate steps on its multiplier,
// and a final step writes the new entry back. Input is accepted only while idle,
// so a new frame is taken only after the previous one has been written back.
// Reset clears the write position and loads the register defaults. Store entries
// that have not been written since reset read as zero through a fill mark (write
// position plus a wrapped flag), so no clearing pass is needed.
// While the receiver stalls the finished frame is held in the output register;
// one more frame can be taken and processed and then waits in its final step
// until the output register frees.
module universal_comb_fractional_delay (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // sample_left, sample_right
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // out_left, out_right
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ucfd_pkg::CFG_IW-1:0]   cfg_addr_i,
  input  logic [ucfd_pkg::CFG_DW-1:0]   cfg_data_i
);
  import ucfd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_RD_A,
    ST_RD_B,
    ST_LOAD,
    ST_D,
    ST_XH,
    ST_FF,
    ST_BL_LO,
    ST_BL_HI,
    ST_DRY,
    ST_WET_LO,
    ST_WET_HI,
    ST_FIN
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      wp_q;
  logic               wrap_q;
  logic               out_valid_q;
  logic [31:0]        out_data_q;

  logic [15:0]        fb_q;
  logic [15:0]        ff_q;
  logic [15:0]        bl_q;
  logic [15:0]        wet_q;
  logic [25:0]        delay_q;

  logic [31:0]        x_q;
  logic [PW-1:0]      pos_q;
  logic [AW-1:0]      nxt_q;
  logic               v_q;
  logic [WORD_W-1:0]  word_a_q;

  logic [PW-1:0]      vdt_ext;
  logic [PW-1:0]      vdt_c;
  logic [PW-1:0]      pos_raw;
  logic [PW-1:0]      pos_d;
  logic [AW-1:0]      rpi;
  logic [AW-1:0]      nxt_d;
  logic [AW-1:0]      raddr;
  logic               rd_valid;
  logic [WORD_W-1:0]  rdata;
  logic [WORD_W-1:0]  word_b;
  logic [WORD_W-1:0]  wdata;
  logic               advance;
  logic               mem_we;
  lane_ctl_t          lane_ctl;
  lane_step_e         step;
  logic signed [15:0] out_l;
  logic signed [15:0] out_r;
  logic signed [15:0] st_l;
  logic signed [15:0] st_r;
  logic [15:0]        out_r_sel;
  logic [15:0]        st_r_sel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q    <= '0;
      ff_q    <= '0;
      bl_q    <= ONE_Q15;
      wet_q   <= ONE_Q15;
      delay_q <= DELAY_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_FEEDBACK:    fb_q    <= clamp_gain(cfg_data_i[15:0]);
        CFG_FEEDFORWARD: ff_q    <= clamp_gain(cfg_data_i[15:0]);
        CFG_BLEND:       bl_q    <= clamp_gain(cfg_data_i[15:0]);
        CFG_WET:         wet_q   <= clamp_gain(cfg_data_i[15:0]);
        CFG_DELAY:       delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vdt_ext = PW'(delay_q);
  assign vdt_c   = (vdt_ext > SPAN) ? SPAN : ((vdt_ext < MIN_DELAY) ? MIN_DELAY : vdt_ext);
  assign pos_raw = PW'({wp_q, 8'h00}) + SPAN - vdt_c;
  assign pos_d   = (pos_raw >= SPAN) ? pos_raw - SPAN : pos_raw;
  assign rpi     = pos_q[AW+7:8];
  assign nxt_d   = (rpi == LAST_ADDR) ? '0 : rpi + 1'b1;

  assign raddr    = (state_q == ST_RD_B) ? nxt_q : rpi;
  assign rd_valid = wrap_q || (raddr < wp_q);
  assign word_b   = rdata & {WORD_W{v_q}};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign advance       = !out_valid_q || m_axis_tready;
  assign mem_we        = (state_q == ST_FIN) && advance;

  assign out_r_sel = (CHANNELS > 1) ? out_r : '0;
  assign st_r_sel  = (CHANNELS > 1) ? st_r : '0;
  assign wdata     = {st_r_sel, st_l};

  always_comb begin
    case (state_q)
      ST_LOAD:   step = LS_LOAD;
      ST_D:      step = LS_D;
      ST_XH:     step = LS_XH;
      ST_FF:     step = LS_FF;
      ST_BL_LO:  step = LS_BL_LO;
      ST_BL_HI:  step = LS_BL_HI;
      ST_DRY:    step = LS_DRY;
      ST_WET_LO: step = LS_WET_LO;
      ST_WET_HI: step = LS_WET_HI;
      default:   step = LS_HOLD;
    endcase
  end

  assign lane_ctl = '{step: step, frac: pos_q[7:0], fb: fb_q, ff: ff_q, bl: bl_q, wet: wet_q};

  always_ff @(posedge clk_i) begin
    v_q <= rd_valid;
    if (s_axis_tvalid && s_axis_tready) begin
      x_q <= s_axis_tdata;
    end
    if (state_q == ST_ADDR) begin
      pos_q <= pos_d;
    end
    if (state_q == ST_RD_A) begin
      nxt_q <= nxt_d;
    end
    if (state_q == ST_RD_B) begin
      word_a_q <= rdata & {WORD_W{v_q}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (mem_we) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {out_r_sel, out_l};
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= ST_ADDR;
          end
        end
        ST_ADDR:   state_q <= ST_RD_A;
        ST_RD_A:   state_q <= ST_RD_B;
        ST_RD_B:   state_q <= ST_LOAD;
        ST_LOAD:   state_q <= ST_D;
        ST_D:      state_q <= ST_XH;
        ST_XH:     state_q <= ST_FF;
        ST_FF:     state_q <= ST_BL_LO;
        ST_BL_LO:  state_q <= ST_BL_HI;
        ST_BL_HI:  state_q <= ST_DRY;
        ST_DRY:    state_q <= ST_WET_LO;
        ST_WET_LO: state_q <= ST_WET_HI;
        ST_WET_HI: state_q <= ST_FIN;
        ST_FIN: begin
          if (advance) begin
            if (wp_q == LAST_ADDR) begin
              wp_q   <= '0;
              wrap_q <= 1'b1;
            end else begin
              wp_q <= wp_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  ucfd_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ucfd_lane u_lane_left (
    .clk_i   (clk_i),
    .ctl_i   (lane_ctl),
    .x_i     ($signed(x_q[15:0])),
    .a_i     ($signed(word_a_q[15:0])),
    .b_i     ($signed(word_b[15:0])),
    .out_o   (out_l),
    .store_o (st_l)
  );

  ucfd_lane u_lane_right (
    .clk_i   (clk_i),
    .ctl_i   (lane_ctl),
    .x_i     ($signed(x_q[31:16])),
    .a_i     ($signed(word_a_q[31:16])),
    .b_i     ($signed(word_b[31:16])),
    .out_o   (out_r),
    .store_o (st_r)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a frame is in flight");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result appeared outside the final step");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_A) |-> (pos_q < SPAN))
    else $error("read position beyond the store");

  a_write_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (wp_q != $past(wp_q)) && out_valid_q)
    else $error("store write without write position advance");
`endif

endmodule
